>>> design/image_affine_warp_nearest_defines.svh
// Assertion helpers shared by the warp block.
// Each macro expands to one labeled concurrent assertion on the block clock,
// disabled while reset is high.
`ifndef IMAGE_AFFINE_WARP_NEAREST_DEFINES_SVH
`define IMAGE_AFFINE_WARP_NEAREST_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define IAWN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define IAWN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/iawn_pkg.sv
`timescale 1ns / 1ps

package iawn_pkg;

   // Frame geometry
   localparam int FRAME_ROWS  = 256;
   localparam int FRAME_COLS  = 256;
   localparam int FRAME_DEPTH = FRAME_ROWS * FRAME_COLS;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);
   localparam int ROW_W       = $clog2(FRAME_ROWS);
   localparam int COL_W       = $clog2(FRAME_COLS);

   // Field and register widths
   localparam int PIX_W      = 8;
   localparam int CRD_W      = 8;
   localparam int COEF_W     = 18;
   localparam int OFS_W      = 24;
   localparam int FRAC_BITS  = 14;
   localparam int PROD_W     = COEF_W + CRD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int MAP_W      = SUM_W - FRAC_BITS;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = OFS_W;

   typedef logic        [PIX_W-1:0]  pixel_type;
   typedef logic        [CRD_W-1:0]  coord_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [OFS_W-1:0]  ofs_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [MAP_W-1:0]  map_type;
   typedef logic        [ADDR_W-1:0] addr_type;
   typedef logic        [ROW_W-1:0]  row_type;
   typedef logic        [COL_W-1:0]  col_type;

   localparam coef_type COEF_ONE  = coef_type'(1 << FRAC_BITS);
   localparam sum_type  FRAC_MASK = sum_type'((1 << FRAC_BITS) - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_ROW_FROM_ROW = 3'd0,
      CSR_COEF_ROW_FROM_COL = 3'd1,
      CSR_COEF_COL_FROM_ROW = 3'd2,
      CSR_COEF_COL_FROM_COL = 3'd3,
      CSR_OFFSET_ROW        = 3'd4,
      CSR_OFFSET_COL        = 3'd5,
      CSR_WARP_MODE         = 3'd6
   } csr_idx_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      WARP_FORWARD  = 1'b0,
      WARP_BACKWARD = 1'b1
   } mode_type;

   // Stage enables handed to the coordinate mapper
   typedef struct packed {
      logic mul;
      logic sum;
   } map_en_type;

endpackage

>>> design/iawn_ram.sv
`timescale 1ns / 1ps

module iawn_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/iawn_map.sv
`timescale 1ns / 1ps

module iawn_map (
   input  logic                  clock,
   input  iawn_pkg::map_en_type  en,
   input  iawn_pkg::coef_type    coef_from_row,
   input  iawn_pkg::coef_type    coef_from_col,
   input  iawn_pkg::ofs_type     offset,
   input  iawn_pkg::coord_type   pixel_row,
   input  iawn_pkg::coord_type   pixel_col,
   output iawn_pkg::map_type     mapped
);

   iawn_pkg::prod_type prod_row_ff, prod_row_in;
   iawn_pkg::prod_type prod_col_ff, prod_col_in;
   iawn_pkg::sum_type  sum_ff, sum_in;
   iawn_pkg::sum_type  biased;

   always_comb begin
      prod_row_in = iawn_pkg::prod_type'(coef_from_row)
                  * iawn_pkg::prod_type'($signed({1'b0, pixel_row}));
      prod_col_in = iawn_pkg::prod_type'(coef_from_col)
                  * iawn_pkg::prod_type'($signed({1'b0, pixel_col}));
      sum_in      = iawn_pkg::sum_type'(prod_row_ff) + iawn_pkg::sum_type'(prod_col_ff)
                  + iawn_pkg::sum_type'(offset);
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_row_ff <= prod_row_in;
         prod_col_ff <= prod_col_in;
      end
      if (en.sum) begin
         sum_ff <= sum_in;
      end
   end

   // round toward zero: bias negative sums up by one less than the scale
   always_comb begin
      biased = sum_ff + (sum_ff[iawn_pkg::SUM_W-1] ? iawn_pkg::FRAC_MASK : '0);
      mapped = biased[iawn_pkg::SUM_W-1:iawn_pkg::FRAC_BITS];
   end

endmodule

>>> design/image_affine_warp_nearest.sv
`timescale 1ns / 1ps
// Channel   Dir  Ports                        Contents
// req       in   req_tvalid/tready/tdata/tuser  tdata: row, col, value; tuser: operation
// rsp       out  rsp_tvalid/tready/tdata/tuser  tdata: result_value; tuser: in_range
// csr       in   csr_wen/csr_addr/csr_wdata     register write, no read-back
//
// One item per cycle is accepted while req_tready is high; a query result passes the input,
// product, sum, address and read stages, each a register, before it leaves.
// The frame RAM serves one load write or one query read per cycle, never both.
// After reset a clearing pass zeroes the frame, one pixel a cycle, over all FRAME_DEPTH
// addresses (65536 for a 256 x 256 frame); req_tready stays low meanwhile.
// Stages advance independently, so bubbles collapse and a load passes a stalled result.

`include "image_affine_warp_nearest_defines.svh"

module image_affine_warp_nearest (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // pixel_row, pixel_col, pixel_value
   input  logic                              req_tuser,  // operation
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // result_value
   output logic                              rsp_tuser,  // in_range
   // configuration write port
   input  logic                              csr_wen,
   input  logic [iawn_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [iawn_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // ---------------------------------------------------------------- config
   iawn_pkg::coef_type coef_rr_ff, coef_rr_in;
   iawn_pkg::coef_type coef_rc_ff, coef_rc_in;
   iawn_pkg::coef_type coef_cr_ff, coef_cr_in;
   iawn_pkg::coef_type coef_cc_ff, coef_cc_in;
   iawn_pkg::ofs_type  offset_row_ff, offset_row_in;
   iawn_pkg::ofs_type  offset_col_ff, offset_col_in;
   iawn_pkg::mode_type warp_mode_ff, warp_mode_in;

   always_comb begin
      coef_rr_in    = coef_rr_ff;
      coef_rc_in    = coef_rc_ff;
      coef_cr_in    = coef_cr_ff;
      coef_cc_in    = coef_cc_ff;
      offset_row_in = offset_row_ff;
      offset_col_in = offset_col_ff;
      warp_mode_in  = warp_mode_ff;
      if (csr_wen) begin
         // drop writes beyond the register list; ignore bits above each width
         unique case (csr_addr)
            iawn_pkg::CSR_COEF_ROW_FROM_ROW:
               coef_rr_in = iawn_pkg::coef_type'(csr_wdata[iawn_pkg::COEF_W-1:0]);
            iawn_pkg::CSR_COEF_ROW_FROM_COL:
               coef_rc_in = iawn_pkg::coef_type'(csr_wdata[iawn_pkg::COEF_W-1:0]);
            iawn_pkg::CSR_COEF_COL_FROM_ROW:
               coef_cr_in = iawn_pkg::coef_type'(csr_wdata[iawn_pkg::COEF_W-1:0]);
            iawn_pkg::CSR_COEF_COL_FROM_COL:
               coef_cc_in = iawn_pkg::coef_type'(csr_wdata[iawn_pkg::COEF_W-1:0]);
            iawn_pkg::CSR_OFFSET_ROW:
               offset_row_in = iawn_pkg::ofs_type'(csr_wdata);
            iawn_pkg::CSR_OFFSET_COL:
               offset_col_in = iawn_pkg::ofs_type'(csr_wdata);
            iawn_pkg::CSR_WARP_MODE:
               warp_mode_in = iawn_pkg::mode_type'(csr_wdata[0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_rr_ff    <= iawn_pkg::COEF_ONE;
         coef_rc_ff    <= '0;
         coef_cr_ff    <= '0;
         coef_cc_ff    <= iawn_pkg::COEF_ONE;
         offset_row_ff <= '0;
         offset_col_ff <= '0;
         warp_mode_ff  <= iawn_pkg::WARP_BACKWARD;
      end else begin
         coef_rr_ff    <= coef_rr_in;
         coef_rc_ff    <= coef_rc_in;
         coef_cr_ff    <= coef_cr_in;
         coef_cc_ff    <= coef_cc_in;
         offset_row_ff <= offset_row_in;
         offset_col_ff <= offset_col_in;
         warp_mode_ff  <= warp_mode_in;
      end
   end

   // ---------------------------------------------------------------- clearing pass
   logic               clearing_ff, clearing_in;
   iawn_pkg::addr_type clear_cnt_ff, clear_cnt_in;
   logic               clear_last;

   always_comb begin
      clear_last   = (clear_cnt_ff == iawn_pkg::addr_type'(iawn_pkg::FRAME_DEPTH - 1));
      clearing_in  = clearing_ff && !clear_last;
      clear_cnt_in = clearing_ff ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // ---------------------------------------------------------------- pipeline
   // stage 1: input register, stage 2: products, stage 3: sums,
   // stage 4: frame address and range verdict, stage 5: read data out
   logic                v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                v4_ff, v4_in, v5_ff, v5_in;
   iawn_pkg::op_type    op1_ff, op2_ff, op3_ff;
   iawn_pkg::coord_type row1_ff, row2_ff, row3_ff;
   iawn_pkg::coord_type col1_ff, col2_ff, col3_ff;
   iawn_pkg::pixel_type val1_ff, val2_ff, val3_ff, val4_ff;
   logic                query4_ff, query4_in;
   logic                ok4_ff, ok4_in;
   iawn_pkg::row_type   row4_ff, row4_in;
   iawn_pkg::col_type   col4_ff, col4_in;
   logic                hit5_ff, hit5_in;

   logic en1, en2, en3, en4, en5, go4;

   // stage enables: a stage takes new content when empty or when it moves on;
   // a load in stage 4 never waits for the result register
   always_comb begin
      en5 = !v5_ff || rsp_tready;
      go4 = v4_ff && (!query4_ff || en5);
      en4 = !v4_ff || go4;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_tready = en1 && !clearing_ff;

   // coordinate mappers, one per output axis
   iawn_pkg::map_en_type map_en;
   iawn_pkg::map_type    mapped_row, mapped_col;

   always_comb begin
      map_en.mul = en2;
      map_en.sum = en3;
   end

   iawn_map u_map_row (
      .clock         (clock),
      .en            (map_en),
      .coef_from_row (coef_rr_ff),
      .coef_from_col (coef_rc_ff),
      .offset        (offset_row_ff),
      .pixel_row     (row1_ff),
      .pixel_col     (col1_ff),
      .mapped        (mapped_row)
   );

   iawn_map u_map_col (
      .clock         (clock),
      .en            (map_en),
      .coef_from_row (coef_cr_ff),
      .coef_from_col (coef_cc_ff),
      .offset        (offset_col_ff),
      .pixel_row     (row1_ff),
      .pixel_col     (col1_ff),
      .mapped        (mapped_col)
   );

   // stage 3 -> 4: pick own or mapped coordinate and decide whether it hits the frame
   logic use_map, own_inside, map_inside, is_query3;

   always_comb begin
      is_query3  = (op3_ff == iawn_pkg::OP_QUERY);
      // forward mode maps loads, backward mode maps queries
      use_map    = is_query3 == (warp_mode_ff == iawn_pkg::WARP_BACKWARD);
      own_inside = (int'(row3_ff) < iawn_pkg::FRAME_ROWS)
                && (int'(col3_ff) < iawn_pkg::FRAME_COLS);
      map_inside = !mapped_row[iawn_pkg::MAP_W-1]
                && (mapped_row < iawn_pkg::map_type'(iawn_pkg::FRAME_ROWS))
                && !mapped_col[iawn_pkg::MAP_W-1]
                && (mapped_col < iawn_pkg::map_type'(iawn_pkg::FRAME_COLS));
      // a mapped load still needs its own source pixel inside the frame
      ok4_in     = use_map ? (map_inside && (is_query3 || own_inside)) : own_inside;
      query4_in  = is_query3;
      row4_in    = use_map ? iawn_pkg::row_type'(mapped_row) : iawn_pkg::row_type'(row3_ff);
      col4_in    = use_map ? iawn_pkg::col_type'(mapped_col) : iawn_pkg::col_type'(col3_ff);
   end

   // valid bits
   always_comb begin
      v1_in = en1 ? (req_tvalid && req_tready) : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      v5_in = en5 ? (v4_ff && query4_ff) : v5_ff;
      hit5_in = en5 ? ok4_ff : hit5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff  <= iawn_pkg::op_type'(req_tuser);
         row1_ff <= req_tdata[7:0];
         col1_ff <= req_tdata[15:8];
         val1_ff <= req_tdata[23:16];
      end
      if (en2) begin
         op2_ff  <= op1_ff;
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
         val2_ff <= val1_ff;
      end
      if (en3) begin
         op3_ff  <= op2_ff;
         row3_ff <= row2_ff;
         col3_ff <= col2_ff;
         val3_ff <= val2_ff;
      end
      if (en4) begin
         query4_ff <= query4_in;
         ok4_ff    <= ok4_in;
         row4_ff   <= row4_in;
         col4_ff   <= col4_in;
         val4_ff   <= val3_ff;
      end
      hit5_ff <= hit5_in;
   end

   // ---------------------------------------------------------------- frame store
   iawn_pkg::addr_type  addr4;
   logic                ram_wr_en, ram_rd_en;
   iawn_pkg::addr_type  ram_wr_addr;
   iawn_pkg::pixel_type ram_wr_data, ram_rd_data;

   always_comb begin
      addr4 = iawn_pkg::addr_type'(iawn_pkg::addr_type'(row4_ff)
                                   * iawn_pkg::addr_type'(iawn_pkg::FRAME_COLS))
            + iawn_pkg::addr_type'(col4_ff);
      // the clearing pass owns the write port; no item is in flight then
      ram_wr_en   = clearing_ff || (v4_ff && !query4_ff && ok4_ff);
      ram_wr_addr = clearing_ff ? clear_cnt_ff : addr4;
      ram_wr_data = clearing_ff ? '0 : val4_ff;
      ram_rd_en   = v4_ff && query4_ff && ok4_ff && en5;
   end

   iawn_ram #(
      .DATA_W (iawn_pkg::PIX_W),
      .DEPTH  (iawn_pkg::FRAME_DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr4),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- result
   assign rsp_tvalid = v5_ff;
   assign rsp_tuser  = hit5_ff;
   assign rsp_tdata  = hit5_ff ? ram_rd_data : '0;

   // ---------------------------------------------------------------- checks
   `IAWN_ASSERT_NOW(a_no_accept_while_clearing, clearing_ff, !req_tready,
      "item accepted during clearing pass")
   `IAWN_ASSERT_NOW(a_one_ram_op, ram_wr_en, !ram_rd_en,
      "frame write and read in the same cycle")
   `IAWN_ASSERT_NOW(a_miss_is_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0,
      "out-of-range result carries nonzero value")
   `IAWN_ASSERT_NEXT(a_clear_runs_to_end, clearing_ff && !clear_last, clearing_ff,
      "clearing pass ended early")

endmodule
